FILE: sv/bps_pkg.sv
`timescale 1ns / 1ps

package bps_pkg;

  localparam int unsigned REG_W = 12;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PHASE_W = 13;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_PLAY = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  localparam logic [2:0] PAT_NONE = 3'd0;
  localparam logic [2:0] PAT_BUTTON = 3'd1;
  localparam logic [2:0] PAT_MESSAGE = 3'd2;
  localparam logic [2:0] PAT_CONNECTED = 3'd3;
  localparam logic [2:0] PAT_ERROR = 3'd4;
  localparam logic [2:0] PAT_EMERGENCY = 3'd5;

  localparam logic [1:0] REG_SHORT_BEEP = 2'd0;
  localparam logic [1:0] REG_LONG_BEEP = 2'd1;
  localparam logic [1:0] REG_SPACING = 2'd2;
  localparam logic [1:0] REG_HALF_PERIOD = 2'd3;

  localparam logic [REG_W-1:0] SHORT_BEEP_RST = 12'd50;
  localparam logic [REG_W-1:0] LONG_BEEP_RST = 12'd300;
  localparam logic [REG_W-1:0] SPACING_RST = 12'd150;
  localparam logic [REG_W-1:0] HALF_PERIOD_RST = 12'd250;

  typedef struct packed {
    logic [REG_W-1:0] short_beep_ms;
    logic [REG_W-1:0] long_beep_ms;
    logic [REG_W-1:0] beep_spacing_ms;
    logic [REG_W-1:0] alarm_half_period_ms;
  } cfg_t;

  typedef struct packed {
    logic       buzzer_on;
    logic [2:0] active_pattern;
  } result_t;

  typedef struct packed {
    logic       step;
    logic [1:0] kind;
    logic [2:0] pattern;
  } cmd_t;

endpackage

FILE: sv/bps_if.sv
`timescale 1ns / 1ps

interface bps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] pattern;

  modport source (output valid, output kind, output pattern, input ready);
  modport sink (input valid, input kind, input pattern, output ready);
endinterface

interface bps_out_if;
  logic       valid;
  logic       ready;
  logic       buzzer_on;
  logic [2:0] active_pattern;

  modport source (output valid, output buzzer_on, output active_pattern, input ready);
  modport sink (input valid, input buzzer_on, input active_pattern, output ready);
endinterface

FILE: sv/bps_regs.sv
`timescale 1ns / 1ps

module bps_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bps_pkg::ADDR_W-1:0]  paddr,
  input  logic [bps_pkg::DATA_W-1:0]  pwdata,
  output logic [bps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bps_pkg::cfg_t               cfg
);
  import bps_pkg::*;

  logic [1:0]       reg_sel;
  logic             wr_en;
  logic [REG_W-1:0] rd_val;

  assign reg_sel = paddr[3:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_beep_ms <= SHORT_BEEP_RST;
      cfg.long_beep_ms <= LONG_BEEP_RST;
      cfg.beep_spacing_ms <= SPACING_RST;
      cfg.alarm_half_period_ms <= HALF_PERIOD_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SHORT_BEEP:  cfg.short_beep_ms <= pwdata[REG_W-1:0];
        REG_LONG_BEEP:   cfg.long_beep_ms <= pwdata[REG_W-1:0];
        REG_SPACING:     cfg.beep_spacing_ms <= pwdata[REG_W-1:0];
        REG_HALF_PERIOD: cfg.alarm_half_period_ms <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SHORT_BEEP:  rd_val = cfg.short_beep_ms;
      REG_LONG_BEEP:   rd_val = cfg.long_beep_ms;
      REG_SPACING:     rd_val = cfg.beep_spacing_ms;
      REG_HALF_PERIOD: rd_val = cfg.alarm_half_period_ms;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = {{(DATA_W-REG_W){1'b0}}, rd_val};

endmodule

FILE: sv/bps_engine.sv
`timescale 1ns / 1ps

module bps_engine (
  input  logic            clk,
  input  logic            rst,
  input  bps_pkg::cfg_t   cfg,
  input  bps_pkg::cmd_t   cmd,
  output bps_pkg::result_t result_next
);
  import bps_pkg::*;

  logic [2:0]         current_pattern, current_pattern_next;
  logic [1:0]         step_index, step_index_next;
  logic               sounding, sounding_next;
  logic [TIME_W-1:0]  pattern_elapsed, pattern_elapsed_next;
  logic [PHASE_W-1:0] alarm_phase, alarm_phase_next;
  logic [TIME_W-1:0]  sound_elapsed, sound_elapsed_next;
  logic [REG_W-1:0]   sound_length, sound_length_next;

  // timer advance on a tick, before the pattern step
  logic [TIME_W-1:0]  pe_t, se_t;
  logic [PHASE_W:0]   ap_inc, period;
  logic [PHASE_W-1:0] ap_t;
  logic               snd_t;
  logic               spacing_hit, twice_hit;
  logic [REG_W-1:0]   single_len;

  always_comb begin
    pe_t = (pattern_elapsed != {TIME_W{1'b1}}) ? pattern_elapsed + 1'b1 : pattern_elapsed;
    se_t = (sounding && sound_elapsed != {TIME_W{1'b1}}) ? sound_elapsed + 1'b1
                                                         : sound_elapsed;
    ap_inc = {1'b0, alarm_phase} + 1'b1;
    period = {1'b0, cfg.alarm_half_period_ms, 1'b0};
    ap_t = (ap_inc >= period) ? '0 : ap_inc[PHASE_W-1:0];
    snd_t = sounding && !(se_t >= {{(TIME_W-REG_W){1'b0}}, sound_length});
    spacing_hit = pe_t >= {{(TIME_W-REG_W){1'b0}}, cfg.beep_spacing_ms};
    twice_hit = pe_t >= {{(TIME_W-REG_W-1){1'b0}}, cfg.beep_spacing_ms, 1'b0};
    single_len = (current_pattern == PAT_BUTTON) ? cfg.short_beep_ms : cfg.long_beep_ms;
  end

  always_comb begin
    current_pattern_next = current_pattern;
    step_index_next = step_index;
    sounding_next = sounding;
    pattern_elapsed_next = pattern_elapsed;
    alarm_phase_next = alarm_phase;
    sound_elapsed_next = sound_elapsed;
    sound_length_next = sound_length;
    if (cmd.step) begin
      unique case (cmd.kind)
        KIND_TICK: begin
          pattern_elapsed_next = pe_t;
          sound_elapsed_next = se_t;
          alarm_phase_next = ap_t;
          sounding_next = snd_t;
          unique case (current_pattern)
            PAT_BUTTON, PAT_CONNECTED: begin
              if (step_index == 2'd0 && !snd_t) begin
                sounding_next = 1'b1;
                sound_elapsed_next = '0;
                sound_length_next = single_len;
                step_index_next = 2'd1;
              end else if (step_index == 2'd1 && !snd_t) begin
                current_pattern_next = PAT_NONE;
                step_index_next = 2'd0;
              end
            end
            PAT_MESSAGE, PAT_ERROR: begin
              if (step_index == 2'd0 && !snd_t) begin
                sounding_next = 1'b1;
                sound_elapsed_next = '0;
                sound_length_next = cfg.short_beep_ms;
                step_index_next = 2'd1;
              end else if (step_index == 2'd1 && !snd_t && spacing_hit) begin
                sounding_next = 1'b1;
                sound_elapsed_next = '0;
                sound_length_next = cfg.short_beep_ms;
                step_index_next = 2'd2;
              end else if (step_index == 2'd2 && !snd_t &&
                           current_pattern == PAT_MESSAGE) begin
                current_pattern_next = PAT_NONE;
                step_index_next = 2'd0;
              end else if (step_index == 2'd2 && !snd_t && twice_hit) begin
                sounding_next = 1'b1;
                sound_elapsed_next = '0;
                sound_length_next = cfg.short_beep_ms;
                step_index_next = 2'd3;
              end else if (step_index == 2'd3 && !snd_t) begin
                current_pattern_next = PAT_NONE;
                step_index_next = 2'd0;
              end
            end
            PAT_EMERGENCY: begin
              if ({1'b0, ap_t} < {2'b00, cfg.alarm_half_period_ms} && !snd_t) begin
                sounding_next = 1'b1;
                sound_elapsed_next = '0;
                sound_length_next = cfg.alarm_half_period_ms;
              end else if ({1'b0, ap_t} >= {2'b00, cfg.alarm_half_period_ms} && snd_t) begin
                sounding_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
        KIND_PLAY: begin
          if (cmd.pattern <= PAT_EMERGENCY && cmd.pattern != current_pattern) begin
            current_pattern_next = cmd.pattern;
            step_index_next = 2'd0;
            sounding_next = 1'b0;
            pattern_elapsed_next = '0;
            alarm_phase_next = '0;
          end
        end
        KIND_STOP: begin
          current_pattern_next = PAT_NONE;
          step_index_next = 2'd0;
          sounding_next = 1'b0;
          pattern_elapsed_next = '0;
          alarm_phase_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_pattern <= PAT_NONE;
      step_index <= '0;
      sounding <= 1'b0;
      pattern_elapsed <= '0;
      alarm_phase <= '0;
      sound_elapsed <= '0;
      sound_length <= '0;
    end else begin
      current_pattern <= current_pattern_next;
      step_index <= step_index_next;
      sounding <= sounding_next;
      pattern_elapsed <= pattern_elapsed_next;
      alarm_phase <= alarm_phase_next;
      sound_elapsed <= sound_elapsed_next;
      sound_length <= sound_length_next;
    end
  end

  assign result_next.buzzer_on = sounding_next;
  assign result_next.active_pattern = current_pattern_next;

endmodule

FILE: sv/beep_pattern_sequencer.sv
`timescale 1ns / 1ps

// Buzzer pattern sequencer. Each input item (a 1 ms tick, a play command or a
// stop) yields one result item with the buzzer level and the running pattern.
// An item is captured in an input register and applied to the pattern state
// once the output register is empty or being read; its result lands in that
// output register, and one item per cycle is sustained while the result side
// keeps taking items. Timing registers are on the APB port at byte addresses
// 0, 4, 8 and 12 and should be written only while no item is in flight.
module beep_pattern_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  bps_in_if.sink                      item_in,
  bps_out_if.source                   result_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bps_pkg::ADDR_W-1:0]  paddr,
  input  logic [bps_pkg::DATA_W-1:0]  pwdata,
  output logic [bps_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bps_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  result_t result_next;
  result_t result;

  logic       hold_valid;
  logic [1:0] hold_kind;
  logic [2:0] hold_pattern;
  logic       advance;
  logic       out_valid;

  assign advance = hold_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_in.ready) begin
      hold_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      hold_kind <= item_in.kind;
      hold_pattern <= item_in.pattern;
    end
  end

  assign cmd.step = advance;
  assign cmd.kind = hold_kind;
  assign cmd.pattern = hold_pattern;

  bps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bps_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.buzzer_on = result.buzzer_on;
  assign result_out.active_pattern = result.active_pattern;

  a_sound_needs_pattern: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.buzzer_on |-> result_out.active_pattern != PAT_NONE)
    else $error("buzzer on with no pattern");

  a_pattern_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.active_pattern <= PAT_EMERGENCY)
    else $error("active pattern out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_out.valid |-> item_in.ready)
    else $error("input stalled with empty output");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    advance && hold_kind == KIND_STOP |=>
      result_out.valid && !result_out.buzzer_on && result_out.active_pattern == PAT_NONE)
    else $error("stop did not clear pattern");

endmodule
